[src/life_pkg.sv]
// shared codes and controller/datapath interface types for the life block
`timescale 1ns / 1ps
`default_nettype none

package life_pkg;

    localparam int FIELD_W  = 7;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_SET     = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ROW_BAD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COL_BAD = 2'd2;

    // birth and survival neighbor counts
    localparam logic [3:0] BIRTH_CNT   = 4'd3;
    localparam logic [3:0] SURVIVE_CNT = 4'd2;

    typedef struct packed {
        logic load_req;   // latch row, column and range status
        logic clear_grid; // drop every row back to dead
        logic rd_req;     // read the requested row
        logic set_wr;     // write requested row with the cell set
        logic adv_start;  // read row 0, empty window top
        logic adv_prime;  // fill window middle, read row 1
        logic adv_step;   // compute and write one row, slide window
        logic out_load;   // load the result registers
        logic out_alive;  // result carries the read cell value
        logic out_status; // result carries the range status
    } t_dp_cmd;

    typedef struct packed {
        logic req_ok;   // requested cell is inside the grid
        logic last_row; // step counter is on the bottom row
    } t_dp_sts;

endpackage

`default_nettype wire

[src/life_dp.sv]
// datapath: grid memory, row valid bits, three-row window and next-row logic
`timescale 1ns / 1ps
`default_nettype none

module life_dp #(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire life_pkg::t_dp_cmd              i_cmd,
    output life_pkg::t_dp_sts                   o_sts,
    input  wire  [life_pkg::FIELD_W-1:0]        i_cell_row,
    input  wire  [life_pkg::FIELD_W-1:0]        i_cell_col,
    output logic                                o_cell_alive,
    output logic [life_pkg::STATUS_W-1:0]       o_status
);

    localparam int RAW = $clog2(ROWS);
    localparam int CAW = $clog2(COLS);
    localparam logic [life_pkg::FIELD_W-1:0] ROW_MAX = life_pkg::FIELD_W'(ROWS);
    localparam logic [life_pkg::FIELD_W-1:0] COL_MAX = life_pkg::FIELD_W'(COLS);
    localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);
    localparam logic [RAW:0]   ROW_CNT  = (RAW + 1)'(ROWS);

    logic [COLS-1:0] mem [ROWS];
    logic [ROWS-1:0] r_row_vld;
    logic [COLS-1:0] r_rd_data;
    logic            r_rd_vld;

    logic [RAW-1:0]                r_req_row;
    logic [CAW-1:0]                r_req_col;
    logic [life_pkg::STATUS_W-1:0] r_req_status;

    logic [RAW-1:0]  r_cnt;
    logic            r_below_ok;
    logic [COLS-1:0] r_win_top;
    logic [COLS-1:0] r_win_mid;

    logic                          rd_en;
    logic [RAW-1:0]                rd_addr;
    logic                          wr_en;
    logic [RAW-1:0]                wr_addr;
    logic [COLS-1:0]               wr_data;
    logic [COLS-1:0]               rd_row;
    logic [COLS-1:0]               below_row;
    logic [COLS-1:0]               next_row;
    logic [RAW:0]                  cnt_plus2;
    logic                          plus2_ok;
    logic [life_pkg::STATUS_W-1:0] n_req_status;

    // unwritten rows read as dead
    assign rd_row    = r_rd_vld ? r_rd_data : '0;
    assign below_row = r_below_ok ? rd_row : '0;
    assign cnt_plus2 = {1'b0, r_cnt} + (RAW + 1)'(2);
    assign plus2_ok  = cnt_plus2 < ROW_CNT;

    always_comb begin
        if (i_cell_row == '0 || i_cell_row > ROW_MAX) begin
            n_req_status = life_pkg::ST_ROW_BAD;
        end else if (i_cell_col == '0 || i_cell_col > COL_MAX) begin
            n_req_status = life_pkg::ST_COL_BAD;
        end else begin
            n_req_status = life_pkg::ST_OK;
        end
    end

    // B3/S23 on one row, with dead cells past both edges
    always_comb begin
        logic [COLS+1:0] ext_top;
        logic [COLS+1:0] ext_mid;
        logic [COLS+1:0] ext_bot;
        logic [3:0]      nbr;
        ext_top = {1'b0, r_win_top, 1'b0};
        ext_mid = {1'b0, r_win_mid, 1'b0};
        ext_bot = {1'b0, below_row, 1'b0};
        next_row = '0;
        for (int c = 0; c < COLS; c++) begin
            nbr = 4'(ext_top[c]) + 4'(ext_top[c+1]) + 4'(ext_top[c+2])
                + 4'(ext_bot[c]) + 4'(ext_bot[c+1]) + 4'(ext_bot[c+2])
                + 4'(ext_mid[c]) + 4'(ext_mid[c+2]);
            if (nbr == life_pkg::BIRTH_CNT) begin
                next_row[c] = 1'b1;
            end else if (nbr == life_pkg::SURVIVE_CNT) begin
                next_row[c] = r_win_mid[c];
            end else begin
                next_row[c] = 1'b0;
            end
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_req_row;
        if (i_cmd.rd_req) begin
            rd_en = 1'b1;
        end else if (i_cmd.adv_start) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if (i_cmd.adv_prime) begin
            rd_en   = 1'b1;
            rd_addr = RAW'(1);
        end else if (i_cmd.adv_step) begin
            rd_en   = plus2_ok;
            rd_addr = cnt_plus2[RAW-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_req_row;
        wr_data = rd_row | (COLS'(1) << r_req_col);
        if (i_cmd.set_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.adv_step) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt;
            wr_data = next_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_row_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.clear_grid) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_row    <= RAW'(i_cell_row - life_pkg::FIELD_W'(1));
            r_req_col    <= CAW'(i_cell_col - life_pkg::FIELD_W'(1));
            r_req_status <= n_req_status;
        end
        if (i_cmd.adv_start) begin
            r_cnt     <= '0;
            r_win_top <= '0;
        end else if (i_cmd.adv_prime) begin
            r_win_mid  <= rd_row;
            r_below_ok <= 1'b1;
        end else if (i_cmd.adv_step) begin
            r_win_top  <= r_win_mid;
            r_win_mid  <= below_row;
            r_below_ok <= plus2_ok;
            r_cnt      <= r_cnt + RAW'(1);
        end
        if (i_cmd.out_load) begin
            o_cell_alive <= i_cmd.out_alive & rd_row[r_req_col];
            o_status     <= i_cmd.out_status ? r_req_status : life_pkg::ST_OK;
        end
    end

    assign o_sts.req_ok   = (r_req_status == life_pkg::ST_OK);
    assign o_sts.last_row = (r_cnt == LAST_ROW);

endmodule

`default_nettype wire

[src/life_ctrl.sv]
// controller: request decode and sequencing of the datapath
`timescale 1ns / 1ps
`default_nettype none

module life_ctrl (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  [life_pkg::OP_W-1:0]     i_op,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output life_pkg::t_dp_cmd             o_cmd,
    input  wire life_pkg::t_dp_sts        i_sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MEM    = 3'd2;
    localparam logic [2:0] S_PRIME  = 3'd3;
    localparam logic [2:0] S_STEP   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic [life_pkg::OP_W-1:0] r_op;
    logic                      accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_req = accept;
        n_state        = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_op)
                    life_pkg::OP_CLEAR: begin
                        o_cmd.clear_grid = 1'b1;
                        o_cmd.out_load   = 1'b1;
                        n_state          = S_OUT;
                    end
                    life_pkg::OP_ADVANCE: begin
                        o_cmd.adv_start = 1'b1;
                        n_state         = S_PRIME;
                    end
                    default: begin
                        if (i_sts.req_ok) begin
                            o_cmd.rd_req = 1'b1;
                            n_state      = S_MEM;
                        end else begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_status = 1'b1;
                            n_state          = S_OUT;
                        end
                    end
                endcase
            end
            S_MEM: begin
                o_cmd.set_wr     = (r_op == life_pkg::OP_SET);
                o_cmd.out_alive  = (r_op == life_pkg::OP_READ);
                o_cmd.out_load   = 1'b1;
                o_cmd.out_status = 1'b1;
                n_state          = S_OUT;
            end
            S_PRIME: begin
                o_cmd.adv_prime = 1'b1;
                n_state         = S_STEP;
            end
            S_STEP: begin
                o_cmd.adv_step = 1'b1;
                if (i_sts.last_row) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_op;
        end
    end

endmodule

`default_nettype wire

[src/life_generation_step.sv]
// top level of the B3/S23 life grid: controller plus datapath
// usage
//   input channel (i_in_valid / o_in_ready) carries one request: i_op selects
//   clear grid, set a cell alive, advance one generation or read a cell;
//   i_cell_row and i_cell_col are 1-based and used by set and read only
//   output channel (o_out_valid / i_out_ready) returns exactly one result per
//   request: o_cell_alive (read value) and o_status (ok, row or column out
//   of range; row is checked first)
//   from acceptance, clear and out-of-range set/read pass the decode state to
//   the result, set/read also pass the memory state, advance passes decode,
//   prime and a step state per row; one request is worked on at a time and
//   the next is taken the cycle after the result is taken.
//   the advance sweeps the single-port-read grid memory one row per cycle
//   through a three-row window, writing each new row behind the read
//   reset clears the row valid bits, so every cell reads dead; a clear
//   request does the same
//   when the receiver stalls the result is held and no request is taken
`timescale 1ns / 1ps
`default_nettype none

module life_generation_step #(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [life_pkg::OP_W-1:0]          i_op,
    input  wire  [life_pkg::FIELD_W-1:0]       i_cell_row,
    input  wire  [life_pkg::FIELD_W-1:0]       i_cell_col,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic                               o_cell_alive,
    output logic [life_pkg::STATUS_W-1:0]      o_status
);

    // command and status between sequencer and datapath
    life_pkg::t_dp_cmd dp_cmd;
    life_pkg::t_dp_sts dp_sts;

    life_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // grid memory, window and result registers
    life_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_cell_row   (i_cell_row),
        .i_cell_col   (i_cell_col),
        .o_cell_alive (o_cell_alive),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire
